/* design/pal_pkg.sv */
// Shared constants, codes and control types for the positional array list.
package pal_pkg;

   // Parameter defaults
   localparam int CAPACITY_DEFAULT  = 128;
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed payload field widths
   localparam int OP_BITS     = 3;
   localparam int POS_BITS    = 8;
   localparam int DATA_BITS   = 32;
   localparam int STATUS_BITS = 3;
   localparam int LEN_BITS    = 8;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_GET    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_PRIOR  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_NEXT   = 3'd4;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STS_OK    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STS_RANGE = 3'd1;
   localparam logic [STATUS_BITS-1:0] STS_FULL  = 3'd2;
   localparam logic [STATUS_BITS-1:0] STS_EMPTY = 3'd3;
   localparam logic [STATUS_BITS-1:0] STS_NONE  = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_READ,
      ACT_INSERT,
      ACT_DELETE
   } action_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // item accepted, latch and decode it
      logic shift;     // one step of the entry move
      logic finish;    // final insert write / count update
      logic out_load;  // load the result register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type in_action;   // decoded action of the item at the input
      logic       shift_done;  // no moves left and no write pending
      logic       out_free;    // result register can take a new item
   } ctrl_sts_type;

endpackage

/* design/pal_ifs.sv */
// Request and response channel interfaces of the positional array list.
interface pal_req_if;
   import pal_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OP_BITS-1:0]          op;
   logic [POS_BITS-1:0]         position;
   logic signed [DATA_BITS-1:0] value_in;

   modport source (output valid, output op, output position, output value_in, input ready);
   modport sink   (input valid, input op, input position, input value_in, output ready);
endinterface

interface pal_rsp_if;
   import pal_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] value_out;
   logic [STATUS_BITS-1:0]      status;
   logic [LEN_BITS-1:0]         list_length;
   logic                        is_empty;

   modport source (output valid, output value_out, output status, output list_length,
                   output is_empty, input ready);
   modport sink   (input valid, input value_out, input status, input list_length,
                   input is_empty, output ready);
endinterface

/* design/pal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pal_datapath.sv */
// Datapath: decode, entry store, move sequencer, count and result register.
module pal_datapath #(
   parameter int CAPACITY  = pal_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = pal_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pal_pkg::ctrl_cmd_type                 cmd,
   output pal_pkg::ctrl_sts_type                 sts,
   input  logic [pal_pkg::OP_BITS-1:0]           req_op,
   input  logic [pal_pkg::POS_BITS-1:0]          req_position,
   input  logic signed [pal_pkg::DATA_BITS-1:0]  req_value_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pal_pkg::DATA_BITS-1:0]  rsp_value_out,
   output logic [pal_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [pal_pkg::LEN_BITS-1:0]          rsp_list_length,
   output logic                                  rsp_is_empty
);
   import pal_pkg::*;

   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS   = ((COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS) + 1;

   // Item registers
   action_type             action_ff, action_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [ADDR_BITS-1:0]   ptr_ff, ptr_in;
   logic [ADDR_BITS-1:0]   dest_ff, dest_in;
   logic [ADDR_BITS-1:0]   ins_addr_ff, ins_addr_in;
   logic [COUNT_BITS-1:0]  moves_ff, moves_in;
   logic                   pend_ff, pend_in;
   logic [WORD_BITS-1:0]   value_ff, value_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_BITS-1:0]      rsp_status_ff, rsp_status_in;
   logic [LEN_BITS-1:0]         rsp_len_ff, rsp_len_in;
   logic                        rsp_empty_ff, rsp_empty_in;

   // Decode of the item at the input
   action_type             dec_action;
   logic [STATUS_BITS-1:0] dec_status;
   logic [ADDR_BITS-1:0]   dec_ptr;
   logic [COUNT_BITS-1:0]  dec_moves;
   logic [CMP_BITS-1:0]    pos_x;
   logic [CMP_BITS-1:0]    cnt_x;

   // RAM ports
   logic                 ram_wr_en;
   logic [ADDR_BITS-1:0] ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_BITS-1:0] ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 step_read;
   logic                 out_free;

   // Range checks and start values for the incoming item
   always_comb begin
      pos_x      = CMP_BITS'(req_position);
      cnt_x      = CMP_BITS'(count_ff);
      dec_action = ACT_NONE;
      dec_status = STS_OK;
      dec_ptr    = '0;
      dec_moves  = '0;
      priority if (req_op == OP_INSERT) begin
         priority if (pos_x == '0 || pos_x > cnt_x + CMP_BITS'(1)) begin
            dec_status = STS_RANGE;
         end else if (cnt_x == CMP_BITS'(CAPACITY)) begin
            dec_status = STS_FULL;
         end else begin
            dec_action = ACT_INSERT;
            dec_ptr    = ADDR_BITS'(cnt_x - CMP_BITS'(1));
            dec_moves  = COUNT_BITS'(cnt_x - pos_x + CMP_BITS'(1));
         end
      end else if (req_op <= OP_NEXT) begin
         priority if (count_ff == '0) begin
            dec_status = STS_EMPTY;
         end else if (pos_x == '0 || pos_x > cnt_x) begin
            dec_status = STS_RANGE;
         end else begin
            unique case (req_op)
               OP_DELETE: begin
                  dec_action = ACT_DELETE;
                  dec_ptr    = ADDR_BITS'(pos_x);
                  dec_moves  = COUNT_BITS'(cnt_x - pos_x);
               end
               OP_GET: begin
                  dec_action = ACT_READ;
                  dec_ptr    = ADDR_BITS'(pos_x - CMP_BITS'(1));
               end
               OP_PRIOR: begin
                  if (pos_x == CMP_BITS'(1)) begin
                     dec_status = STS_NONE;
                  end else begin
                     dec_action = ACT_READ;
                     dec_ptr    = ADDR_BITS'(pos_x - CMP_BITS'(2));
                  end
               end
               OP_NEXT: begin
                  if (pos_x == cnt_x) begin
                     dec_status = STS_NONE;
                  end else begin
                     dec_action = ACT_READ;
                     dec_ptr    = ADDR_BITS'(pos_x);
                  end
               end
               default: begin
                  dec_action = ACT_NONE;
               end
            endcase
         end
      end else begin
         dec_action = ACT_NONE;
      end
   end

   // Move sequencer: at most one read issued and one write retired per step
   assign step_read = cmd.shift && (moves_ff != '0);

   always_comb begin
      action_in   = action_ff;
      status_in   = status_ff;
      ptr_in      = ptr_ff;
      dest_in     = dest_ff;
      ins_addr_in = ins_addr_ff;
      moves_in    = moves_ff;
      pend_in     = pend_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      if (cmd.load) begin
         action_in   = dec_action;
         status_in   = dec_status;
         ptr_in      = dec_ptr;
         moves_in    = dec_moves;
         pend_in     = 1'b0;
         ins_addr_in = ADDR_BITS'(pos_x - CMP_BITS'(1));
         value_in    = WORD_BITS'($unsigned(req_value_in));
      end
      if (cmd.shift) begin
         pend_in = step_read;
         if (step_read) begin
            moves_in = moves_ff - COUNT_BITS'(1);
            if (action_ff == ACT_INSERT) begin
               ptr_in  = ptr_ff - ADDR_BITS'(1);
               dest_in = ptr_ff + ADDR_BITS'(1);
            end else begin
               ptr_in  = ptr_ff + ADDR_BITS'(1);
               dest_in = ptr_ff - ADDR_BITS'(1);
            end
         end
      end
      if (cmd.finish) begin
         if (action_ff == ACT_INSERT) begin
            count_in = count_ff + COUNT_BITS'(1);
         end else if (action_ff == ACT_DELETE) begin
            count_in = count_ff - COUNT_BITS'(1);
         end
      end
   end

   // RAM port selection
   always_comb begin
      ram_rd_en   = (cmd.load && dec_action == ACT_READ) || step_read;
      ram_rd_addr = cmd.load ? dec_ptr : ptr_ff;
      ram_wr_en   = (cmd.shift && pend_ff) || (cmd.finish && action_ff == ACT_INSERT);
      ram_wr_addr = cmd.finish ? ins_addr_ff : dest_ff;
      ram_wr_data = cmd.finish ? value_ff : ram_rd_data;
   end

   pal_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = (action_ff == ACT_READ) ? $signed(DATA_BITS'(ram_rd_data)) : '0;
         rsp_status_in = status_ff;
         rsp_len_in    = LEN_BITS'(count_ff);
         rsp_empty_in  = (count_ff == '0);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         moves_ff     <= '0;
         action_ff    <= ACT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         moves_ff     <= moves_in;
         action_ff    <= action_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      ptr_ff        <= ptr_in;
      dest_ff       <= dest_in;
      ins_addr_ff   <= ins_addr_in;
      value_ff      <= value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign sts.in_action  = dec_action;
   assign sts.shift_done = (moves_ff == '0) && !pend_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_length = rsp_len_ff;
   assign rsp_is_empty    = rsp_empty_ff;

`ifndef NO_ASSERTIONS
   // Entry count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("entry count above capacity");

   // A move never reads the entry it is writing in the same cycle
   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("store read and write at the same address");

   // A waiting result is never overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // Finishing an insert grows the list by one entry
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && action_ff == ACT_INSERT) |=> (count_ff == $past(count_ff) + COUNT_BITS'(1)))
      else $error("insert did not grow the list");
`endif

endmodule

/* design/pal_controller.sv */
// Controller: sequences accept, entry moves and result hand-off.
module pal_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pal_pkg::ctrl_sts_type sts,
   output pal_pkg::ctrl_cmd_type cmd
);
   import pal_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.in_action == ACT_INSERT || sts.in_action == ACT_DELETE) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_RESPOND;
               end
            end
         end
         S_SHIFT: begin
            if (sts.shift_done) begin
               cmd.finish = 1'b1;
               state_in   = S_RESPOND;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         S_RESPOND: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* design/positional_array_list.sv */
// Get, prior, next, errors and unused ops: the item is accepted and its result is loaded once
// the result register is free. Insert and delete first move the entries at and after the
// position (after it, for delete), then write the new entry (insert) and update the count.
// One item is in work at a time; the next is accepted while the last result waits.
// Reset (synchronous) empties the list and clears control; store contents are not cleared.
// Top level of the positional array list.
module positional_array_list #(
   parameter int CAPACITY  = pal_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = pal_pkg::WORD_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   pal_req_if.sink   req_if,
   pal_rsp_if.source rsp_if
);
   import pal_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   pal_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pal_datapath #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_if.op),
      .req_position    (req_if.position),
      .req_value_in    (req_if.value_in),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_value_out   (rsp_if.value_out),
      .rsp_status      (rsp_if.status),
      .rsp_list_length (rsp_if.list_length),
      .rsp_is_empty    (rsp_if.is_empty)
   );

endmodule
